### rtl/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Sets the window length and the sample width, and defines the chain
// signals that pass from one sorting cell to the next.
// ---------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned Window      = 10;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned MedianIdx   = Window / 2;

  typedef logic [SampleWidth-1:0] sample_t;

  // Flags that ripple from the low end of the sorted row to the high end.
  typedef struct packed {
    logic found;   // the departing sample was already matched below
    logic placed;  // the new sample was already placed below
  } chain_t;

endpackage

### rtl/swm_stream_if.sv
// ---------------------------------------------------------------------------
// swm_stream_if: valid/ready stream carrying one sample word
// A transaction completes on a rising edge with valid and ready both high.
// ---------------------------------------------------------------------------
interface swm_stream_if;

  logic                 valid;
  logic                 ready;
  swm_pkg::sample_t     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### rtl/swm_cell.sv
// ---------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sorted entry. On an update it closes the gap left by the
// departing sample and then opens room for the new one, from the new and
// departing samples, both neighbors' values and the flags rippling up the row.
// ---------------------------------------------------------------------------
module swm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              tail_i,
  input  swm_pkg::sample_t  fresh_i,
  input  swm_pkg::sample_t  gone_i,
  input  swm_pkg::sample_t  right_i,
  input  swm_pkg::sample_t  left_rem_i,
  input  swm_pkg::chain_t   chain_i,
  output swm_pkg::sample_t  value_o,
  output swm_pkg::sample_t  rem_o,
  output swm_pkg::chain_t   chain_o
);
  import swm_pkg::*;

  sample_t value_q, value_d;
  logic    found_here;
  logic    place_here;

  // Removal: every slot from the first match upward takes its right neighbor.
  assign found_here    = chain_i.found | (value_q == gone_i);
  assign rem_o         = found_here ? right_i : value_q;
  assign chain_o.found = found_here;

  // Insertion: the new sample goes ahead of the first larger entry, or last.
  assign place_here     = !chain_i.placed && (tail_i || (fresh_i < rem_o));
  assign chain_o.placed = chain_i.placed | place_here;

  always_comb begin
    if (chain_i.placed) begin
      value_d = left_rem_i;
    end else if (place_here) begin
      value_d = fresh_i;
    end else begin
      value_d = rem_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (en_i) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

### rtl/sliding_window_median_filter.sv
// ---------------------------------------------------------------------------
// sliding_window_median_filter: running median over the last Window samples
//
//   channel    direction  payload              width
//   sample_i   in         sample (unsigned)    SampleWidth
//   median_o   out        median (unsigned)    SampleWidth
//
// Each accepted sample updates the whole sorted row of cells at once;
// the median of the updated window is shown on the next cycle.
// One sample per cycle is sustained while the result side takes results.
// Reset fills both the history line and the sorted row with zeros.
// A new sample is taken whenever no result is waiting or the waiting one
// is taken in the same cycle.
// ---------------------------------------------------------------------------
module sliding_window_median_filter (
  input  logic            clk_i,
  input  logic            rst_ni,
  swm_stream_if.sink      sample_i,
  swm_stream_if.source    median_o
);
  import swm_pkg::*;

  logic    accept;
  logic    out_valid_q;
  sample_t hist_q [Window];
  sample_t fresh;
  sample_t gone;
  sample_t value [Window];
  sample_t rem   [Window];
  chain_t  chain [Window+1];

  assign sample_i.ready = !out_valid_q || median_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;
  assign fresh          = sample_i.data;
  assign gone           = hist_q[Window-1];

  // Arrival history as a shift line; the last tap is the oldest sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) begin
        hist_q[i] <= '0;
      end
    end else if (accept) begin
      hist_q[0] <= fresh;
      for (int i = 1; i < Window; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  assign chain[0] = '0;

  for (genvar k = 0; k < Window; k++) begin : g_cell
    sample_t right;
    sample_t left_rem;

    if (k == Window - 1) begin : g_tail
      assign right = value[k];
    end else begin : g_mid
      assign right = value[k+1];
    end

    if (k == 0) begin : g_head
      assign left_rem = '0;
    end else begin : g_rest
      assign left_rem = rem[k-1];
    end

    swm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .tail_i     (k == Window - 1),
      .fresh_i    (fresh),
      .gone_i     (gone),
      .right_i    (right),
      .left_rem_i (left_rem),
      .chain_i    (chain[k]),
      .value_o    (value[k]),
      .rem_o      (rem[k]),
      .chain_o    (chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (median_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // The row only changes on a transaction, so it holds the pending result.
  assign median_o.valid = out_valid_q;
  assign median_o.data  = value[MedianIdx];

endmodule
